// File: rtl/core/itra_pkg.sv
// ----------------------------------------------------------------------------
// itra_pkg
// Shared types, constants and the digit-to-ASCII mapping for the radix
// converter.
// ----------------------------------------------------------------------------
package itra_pkg;

    localparam int VALUE_W = 31;
    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    // dividend register is padded to a multiple of the per-cycle step
    localparam int DIV_W     = 32;
    localparam int STEP_BITS = 8;
    localparam int DIV_STEPS = DIV_W / STEP_BITS;
    localparam int PHASE_W   = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_ALPHA = 6'd26;

    localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_COLON  = 7'd58;
    localparam logic [CHAR_W-1:0] LETTER_GAP   = 7'd7;
    localparam logic [CHAR_W-1:0] ALPHA_OFFSET = 7'd17;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic               bad;
    } t_item;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(
        input logic [DIGIT_W-1:0] d,
        input logic [RADIX_W-1:0] radix
    );
        logic [CHAR_W-1:0] c;
        c = ASCII_ZERO + {1'b0, d};
        if (radix >= RADIX_DEC) begin
            if (radix == RADIX_ALPHA) begin
                c = c + ALPHA_OFFSET;
            end else if (c >= ASCII_COLON) begin
                c = c + LETTER_GAP;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/core/integer_to_radix_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Flow: input register and queue to the engine, one division pass per digit, then
//   the digit store is read back and a character emitted per digit; bad radix: a
//   lone zero beat. The engine takes no new item until the last character of D
//   digits (up to 31) is out, set by the one division unit and by output stalls.
// Reset: synchronous active-low; clears control, digit store is not cleared.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [itra_pkg::VALUE_W-1:0]  i_value,
    input  logic [itra_pkg::RADIX_W-1:0]  i_radix,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [itra_pkg::CHAR_W-1:0]   o_character,
    output logic                          o_last,
    output logic                          o_bad_radix
);
    import itra_pkg::*;

    logic  w_push;
    logic  w_push_ready;
    t_item w_front_item;
    logic  w_q_valid;
    logic  w_pop;
    t_item w_q_item;

    itra_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_item       (w_front_item)
    );

    itra_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_item       (w_front_item),
        .o_valid      (w_q_valid),
        .i_pop        (w_pop),
        .o_item       (w_q_item)
    );

    itra_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .o_pop       (w_pop),
        .i_item      (w_q_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last),
        .o_bad_radix (o_bad_radix)
    );

endmodule

// File: rtl/core/itra_front.sv
// ----------------------------------------------------------------------------
// itra_front
// Input stage: registers each beat and flags a radix outside 2..36.
// ----------------------------------------------------------------------------
module itra_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [itra_pkg::VALUE_W-1:0]  i_value,
    input  logic [itra_pkg::RADIX_W-1:0]  i_radix,
    output logic                          o_push,
    input  logic                          i_push_ready,
    output itra_pkg::t_item               o_item
);
    import itra_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_accept;

    assign o_ready  = !r_valid || i_push_ready;
    assign w_accept = i_valid && o_ready;
    assign o_push   = r_valid;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.value <= i_value;
            r_item.radix <= i_radix;
            r_item.bad   <= !(i_radix inside {[RADIX_MIN:RADIX_MAX]});
        end
    end

endmodule

// File: rtl/core/itra_queue.sv
// ----------------------------------------------------------------------------
// itra_queue
// Small FIFO between the input stage and the conversion engine.
// ----------------------------------------------------------------------------
module itra_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_push_ready,
    input  itra_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_pop,
    output itra_pkg::t_item o_item
);
    import itra_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign w_wr         = i_push && o_push_ready;
    assign w_rd         = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!w_wr && w_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: rtl/core/itra_back.sv
// ----------------------------------------------------------------------------
// itra_back
// Conversion engine: repeated division by the radix, eight quotient bits a
// cycle, digits kept in a local store and replayed most significant first.
// ----------------------------------------------------------------------------
module itra_back #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_pop,
    input  itra_pkg::t_item              i_item,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [itra_pkg::CHAR_W-1:0]  o_character,
    output logic                         o_last,
    output logic                         o_bad_radix
);
    import itra_pkg::*;

    localparam int AW = $clog2(MAX_DIGITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BAD,
        S_DIV,
        S_RD,
        S_EMIT
    } t_state;

    t_state             r_state,  n_state;
    logic [RADIX_W-1:0] r_radix,  n_radix;
    logic [DIV_W-1:0]   r_dvd,    n_dvd;
    logic [DIGIT_W-1:0] r_rem,    n_rem;
    logic [PHASE_W-1:0] r_phase,  n_phase;
    logic [AW-1:0]      r_cnt,    n_cnt;
    logic [AW-1:0]      r_ptr,    n_ptr;
    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_char,   n_char;
    logic               r_last,   n_last;
    logic               r_bad,    n_bad;

    logic [DIGIT_W-1:0] r_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] r_rd_data;

    logic [DIGIT_W:0]   w_rem;
    logic [DIV_W-1:0]   w_dvd;
    logic               w_out_free;
    logic               w_we;

    assign w_out_free  = !r_out_valid || i_ready;
    assign o_pop       = (r_state == S_IDLE) && i_valid;
    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_bad_radix = r_bad;
    assign w_we        = (r_state == S_DIV) && (r_phase == PHASE_W'(DIV_STEPS - 1));

    // restoring division, STEP_BITS quotient bits per cycle
    always_comb begin
        w_rem = {1'b0, r_rem};
        w_dvd = r_dvd;
        for (int i = 0; i < STEP_BITS; i++) begin
            w_rem = {w_rem[DIGIT_W-1:0], w_dvd[DIV_W-1]};
            w_dvd = {w_dvd[DIV_W-2:0], 1'b0};
            if (w_rem >= {1'b0, r_radix}) begin
                w_rem    = w_rem - {1'b0, r_radix};
                w_dvd[0] = 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_radix     = r_radix;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_out_valid = r_out_valid && !i_ready;
        n_char      = r_char;
        n_last      = r_last;
        n_bad       = r_bad;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_radix = i_item.radix;
                    n_dvd   = {{(DIV_W - VALUE_W){1'b0}}, i_item.value};
                    n_rem   = '0;
                    n_phase = '0;
                    n_cnt   = '0;
                    n_state = i_item.bad ? S_BAD : S_DIV;
                end
            end
            S_BAD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = '0;
                    n_last      = 1'b1;
                    n_bad       = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DIV: begin
                n_dvd   = w_dvd;
                n_rem   = w_rem[DIGIT_W-1:0];
                n_phase = r_phase + 1'b1;
                if (w_we) begin
                    n_rem = '0;
                    if ((w_dvd != '0) && (r_cnt != AW'(MAX_DIGITS - 1))) begin
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_ptr   = r_cnt;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = digit_to_ascii(r_rd_data, r_radix);
                    n_last      = (r_ptr == '0);
                    n_bad       = 1'b0;
                    if (r_ptr == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr - 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_cnt       <= '0;
            r_ptr       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_ptr       <= n_ptr;
        end
        r_radix <= n_radix;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_char  <= n_char;
        r_last  <= n_last;
        r_bad   <= n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_cnt] <= w_rem[DIGIT_W-1:0];
        end
        r_rd_data <= r_mem[r_ptr];
    end

endmodule

// File: rtl/core/itra_checker.sv
// ----------------------------------------------------------------------------
// itra_checker
// Port-level checks on the converter's result channel.
// ----------------------------------------------------------------------------
module itra_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [itra_pkg::CHAR_W-1:0]  o_character,
    input logic                         o_last,
    input logic                         o_bad_radix
);
    import itra_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_character)
            && $stable(o_last) && $stable(o_bad_radix))
        else $error("stalled result beat changed");

    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_radix |-> o_last && (o_character == '0))
        else $error("bad radix beat is not a lone zero beat");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bad_radix |->
            ((o_character >= 7'd48) && (o_character <= 7'd57)) ||
            ((o_character >= 7'd65) && (o_character <= 7'd90)))
        else $error("character outside digit and letter range");

endmodule

bind integer_to_radix_ascii itra_checker u_itra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_character (o_character),
    .o_last      (o_last),
    .o_bad_radix (o_bad_radix)
);

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_to_radix_ascii. A table of directed
// conversions (zero, full-scale values, letter digits, the all-letter base,
// out-of-range bases) runs first, then random conversions under four
// pacing phases on both handshakes. Each character beat is checked against a
// queue fed by table text or a behavioral divide-and-remainder predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_ITEMS  = 34;
    localparam int N_DIRECTED   = 25;
    localparam string PREDICTED = "*";

    typedef logic [itra_pkg::VALUE_W-1:0] t_value;
    typedef logic [itra_pkg::RADIX_W-1:0] t_radix;
    typedef logic [itra_pkg::CHAR_W-1:0]  t_char;

    localparam logic [itra_pkg::CHAR_W-1:0] LETTER_A =
        itra_pkg::ASCII_ZERO + itra_pkg::ALPHA_OFFSET;
    localparam logic [itra_pkg::VALUE_W-1:0] VALUE_FULL = '1;

    typedef struct packed {
        logic [itra_pkg::CHAR_W-1:0] character;
        logic                        last;
        logic                        bad_radix;
    } t_char_beat;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [itra_pkg::VALUE_W-1:0]  i_value = '0;
    logic [itra_pkg::RADIX_W-1:0]  i_radix = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [itra_pkg::CHAR_W-1:0]   o_character;
    logic                          o_last;
    logic                          o_bad_radix;

    t_char_beat pending_chars [$];
    int errors = 0;
    int conversions_sent = 0;
    int bad_radix_sent = 0;
    int chars_checked = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // "*" rows are predicted, "" rows expect the bad radix beat
    logic [itra_pkg::VALUE_W-1:0] dir_value [N_DIRECTED] = '{
        31'd0, 31'd0, 31'd0, 31'd0,
        VALUE_FULL, VALUE_FULL, VALUE_FULL, VALUE_FULL, VALUE_FULL, VALUE_FULL,
        31'd35, 31'd25, 31'd26, 31'd36, 31'd10, 31'd9, 31'd2, 31'd1,
        31'd12345, 31'd12345, 31'd0, VALUE_FULL,
        31'h2AAAAAAA, 31'h55555555, 31'h1234567
    };
    logic [itra_pkg::RADIX_W-1:0] dir_radix [N_DIRECTED] = '{
        6'd10, 6'd26, 6'd2, 6'd36,
        6'd2, 6'd10, 6'd16, 6'd36, 6'd8, 6'd26,
        6'd36, 6'd26, 6'd26, 6'd36, 6'd11, 6'd9, 6'd2, 6'd3,
        6'd0, 6'd1, 6'd37, 6'd63,
        6'd9, 6'd26, 6'd7
    };
    string dir_text [N_DIRECTED] = '{
        "0", "A", "0", "0",
        {"1111111111", "1111111111", "1111111111", "1"}, "2147483647", "7FFFFFFF",
        "ZIK0ZJ", "17777777777", "*",
        "Z", "Z", "BA", "10", "A", "10", "10", "1",
        "", "", "", "",
        "*", "*", "*"
    };

    integer_to_radix_ascii dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last),
        .o_bad_radix (o_bad_radix)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit radix_is_bad(input logic [itra_pkg::RADIX_W-1:0] radix);
        return (radix < itra_pkg::RADIX_MIN) || (radix > itra_pkg::RADIX_MAX);
    endfunction

    function automatic void predict_characters(
        input logic [itra_pkg::VALUE_W-1:0] value,
        input logic [itra_pkg::RADIX_W-1:0] radix
    );
        int unsigned quotient;
        int unsigned digits [32];
        int          n_digits;
        t_char_beat  beat;
        if (radix_is_bad(radix)) begin
            beat = '{character: '0, last: 1'b1, bad_radix: 1'b1};
            pending_chars.push_back(beat);
            return;
        end
        quotient = {1'b0, value};
        n_digits = 0;
        do begin
            digits[n_digits] = quotient % radix;
            quotient = quotient / radix;
            n_digits++;
        end while (quotient != 0);
        for (int k = n_digits - 1; k >= 0; k--) begin
            if (radix == itra_pkg::RADIX_ALPHA) begin
                beat.character = t_char'(LETTER_A + digits[k]);
            end else if (digits[k] < itra_pkg::RADIX_DEC) begin
                beat.character = t_char'(itra_pkg::ASCII_ZERO + digits[k]);
            end else begin
                beat.character = t_char'(LETTER_A + digits[k] - itra_pkg::RADIX_DEC);
            end
            beat.last = (k == 0);
            beat.bad_radix = 1'b0;
            pending_chars.push_back(beat);
        end
    endfunction

    function automatic void push_typed_characters(input string text);
        t_char_beat beat;
        if (text.len() == 0) begin
            beat = '{character: '0, last: 1'b1, bad_radix: 1'b1};
            pending_chars.push_back(beat);
        end
        for (int k = 0; k < text.len(); k++) begin
            beat.character = t_char'(text[k]);
            beat.last = (k == text.len() - 1);
            beat.bad_radix = 1'b0;
            pending_chars.push_back(beat);
        end
    endfunction

    task automatic send_conversion(
        input logic [itra_pkg::VALUE_W-1:0] value,
        input logic [itra_pkg::RADIX_W-1:0] radix
    );
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        i_radix <= radix;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        conversions_sent++;
        if (radix_is_bad(radix)) bad_radix_sent++;
    endtask

    task automatic pick_conversion(
        output logic [itra_pkg::VALUE_W-1:0] value,
        output logic [itra_pkg::RADIX_W-1:0] radix
    );
        int unsigned pick;
        longint      power;
        logic [itra_pkg::RADIX_W-1:0] common_bases [5];
        common_bases = '{6'd2, 6'd10, 6'd16, 6'd26, 6'd36};
        pick = $urandom_range(99);
        if (pick < 10) begin
            case ($urandom_range(2))
                0: radix = 6'd0;
                1: radix = 6'd1;
                default: radix = t_radix'($urandom_range(37, 63));
            endcase
        end else if (pick < 35) begin
            radix = common_bases[$urandom_range(4)];
        end else begin
            radix = t_radix'($urandom_range(2, 36));
        end
        case ($urandom_range(9))
            0: value = '0;
            1: value = t_value'($urandom_range(0, 200));
            2: begin
                power = 1;
                if (!radix_is_bad(radix)) begin
                    repeat ($urandom_range(1, 30)) begin
                        if (power * radix <= longint'(VALUE_FULL)) power = power * radix;
                    end
                end
                value = t_value'($urandom_range(1) ? power : power - 1);
            end
            3: value = VALUE_FULL >> $urandom_range(0, 30);
            4, 5, 6: value = t_value'($urandom);
            default: value = t_value'($urandom >> $urandom_range(1, 30));
        endcase
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : char_check
        t_char_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual char %h last %b bad %b",
                         $time, o_character, o_last, o_bad_radix);
            end else begin
                want = pending_chars.pop_front();
                if (o_character !== want.character) begin
                    errors++;
                    $display("%0t: character mismatch, expected %h actual %h",
                             $time, want.character, o_character);
                end
                if (o_last !== want.last) begin
                    errors++;
                    $display("%0t: last mismatch, expected %b actual %b",
                             $time, want.last, o_last);
                end
                if (o_bad_radix !== want.bad_radix) begin
                    errors++;
                    $display("%0t: bad_radix mismatch, expected %b actual %b",
                             $time, want.bad_radix, o_bad_radix);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no beat for %0d cycles, %0d characters still due",
                 $time, QUIET_LIMIT, pending_chars.size());
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        logic [itra_pkg::VALUE_W-1:0] value;
        logic [itra_pkg::RADIX_W-1:0] radix;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int row = 0; row < N_DIRECTED; row++) begin
            send_conversion(dir_value[row], dir_radix[row]);
            if (dir_text[row] == PREDICTED) begin
                predict_characters(dir_value[row], dir_radix[row]);
            end else begin
                push_typed_characters(dir_text[row]);
            end
        end

        // pacing: none, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            repeat (PHASE_ITEMS) begin
                pick_conversion(value, radix);
                send_conversion(value, radix);
                predict_characters(value, radix);
            end
        end
        i_valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d conversions sent, %0d of them with an out-of-range base;",
                 conversions_sent, bad_radix_sent);
        $display("%0d character beats checked across four handshake pacing phases",
                 chars_checked);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
